// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                     enq;    // insert value, store not full
    logic                     deq;    // shift toward the head, store not empty
    logic signed [DATA_W-1:0] value;
  } spq_cmd_t;

endpackage

// ----- hw/rtl/sorted_array_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Minimum-first priority queue kept as an ascending chain of compare-and-
// shift cells. Equal values leave in arrival order.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_ready in_action in_new_value | sink
//  out     | out_valid out_ready out_status           | source
//          | out_removed_value out_occupancy          |
//
//  All cells compare and shift in parallel in the cycle the beat is
//  accepted, so one beat is accepted per cycle while in_ready is high.
//  The result sits in an output register; a new beat is taken whenever that
//  register is empty or is being drained in the same cycle.
//  Reset clears the entry count and the output valid; cell contents are
//  not reset and are only read below the count.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic signed [spq_pkg::DATA_W-1:0]   in_new_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [spq_pkg::DATA_W-1:0]   out_removed_value,
  output logic [spq_pkg::OCC_W-1:0]           out_occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;

  logic                     accept, full, empty;
  spq_cmd_t                 cmd;
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      gt;
  logic [CAPACITY-1:0]      occ;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);

  assign cmd.enq   = accept && (in_action == ACT_ENQ) && !full;
  assign cmd.deq   = accept && (in_action == ACT_DEQ) && !empty;
  assign cmd.value = in_new_value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     p_occ, p_gt;
      logic signed [DATA_W-1:0] p_entry, n_entry;

      assign occ[i] = (count_r > CW'(i));

      if (i == 0) begin : g_head
        assign p_occ   = 1'b1;
        assign p_gt    = 1'b0;
        assign p_entry = '0;
      end else begin : g_body
        assign p_occ   = occ[i-1];
        assign p_gt    = gt[i-1];
        assign p_entry = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign n_entry = '0;
      end else begin : g_link
        assign n_entry = entry[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occ        (occ[i]),
        .prev_occ   (p_occ),
        .prev_gt    (p_gt),
        .prev_entry (p_entry),
        .next_entry (n_entry),
        .entry      (entry[i]),
        .gt         (gt[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    if (accept) begin
      status_nxt  = ST_DONE;
      removed_nxt = '0;
      unique case (in_action)
        ACT_ENQ: begin
          if (full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        ACT_DEQ: begin
          if (empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            removed_nxt = entry[0];
            count_nxt   = count_r - CW'(1);
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_occupancy     = OCC_W'(count_r);

  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted insert did not grow the count");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq |=> count_r == $past(count_r) - CW'(1))
    else $error("accepted remove did not shrink the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(2) |-> entry[0] <= entry[1])
    else $error("head entries out of order");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_ENQ) && full |=> status_r == ST_OVERFLOW)
    else $error("insert into a full store not flagged");

endmodule

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the
// incoming value and takes data from either neighbor or from the command.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::spq_cmd_t                cmd,
  input  logic                             occ,        // this slot holds an entry
  input  logic                             prev_occ,   // slot toward the head occupied
  input  logic                             prev_gt,    // slot toward the head > value
  input  logic signed [spq_pkg::DATA_W-1:0] prev_entry,
  input  logic signed [spq_pkg::DATA_W-1:0] next_entry,
  output logic signed [spq_pkg::DATA_W-1:0] entry,
  output logic                             gt
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  assign gt    = occ && (entry_r > cmd.value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.deq) begin
      entry_nxt = next_entry;
    end else if (cmd.enq) begin
      // shift larger entries one slot toward the tail, drop value at the boundary
      priority if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt || (!occ && prev_occ)) begin
        entry_nxt = cmd.value;
      end else begin
        entry_nxt = entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted-array priority queue against a mirror of its store: each
// accepted beat updates the mirror and queues the expected status, removed
// value and occupancy, and each result beat is compared with the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int CAPACITY = 16;

  class min_queue_tracker;
    typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] removed;
      logic [OCC_W-1:0]         occupancy;
    } queue_result_t;

    logic signed [DATA_W-1:0] mirror_entries [CAPACITY];
    int                       mirror_count;
    queue_result_t            pending_results [$];
    int                       errors;
    int                       enq_count;
    int                       deq_count;
    int                       overflow_count;
    int                       underflow_count;
    int                       peak_count;
    int                       checked_count;

    function new();
      mirror_count    = 0;
      errors          = 0;
      enq_count       = 0;
      deq_count       = 0;
      overflow_count  = 0;
      underflow_count = 0;
      peak_count      = 0;
      checked_count   = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Update the mirror for one accepted beat and queue what it must produce.
    function void note_request(logic act, logic signed [DATA_W-1:0] val);
      queue_result_t r;
      int            k;
      r.status  = ST_DONE;
      r.removed = '0;
      if (act == ACT_ENQ) begin
        enq_count++;
        if (mirror_count >= CAPACITY) begin
          r.status = ST_OVERFLOW;
          overflow_count++;
        end else begin
          // insert after every entry less than or equal to val
          k = mirror_count;
          while (k > 0 && mirror_entries[k-1] > val) begin
            mirror_entries[k] = mirror_entries[k-1];
            k--;
          end
          mirror_entries[k] = val;
          mirror_count++;
          if (mirror_count > peak_count) peak_count = mirror_count;
        end
      end else begin
        deq_count++;
        if (mirror_count == 0) begin
          r.status = ST_UNDERFLOW;
          underflow_count++;
        end else begin
          r.removed = mirror_entries[0];
          for (k = 0; k + 1 < mirror_count; k++)
            mirror_entries[k] = mirror_entries[k+1];
          mirror_count--;
        end
      end
      r.occupancy = mirror_count[OCC_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status,
                               logic signed [DATA_W-1:0] removed,
                               logic [OCC_W-1:0] occupancy);
      queue_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: status %0d removed %0d occupancy %0d",
                 $time, status, removed, occupancy);
        return;
      end
      exp_r = pending_results.pop_front();
      checked_count++;
      if (status !== exp_r.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp_r.status, status);
      end
      if (removed !== exp_r.removed) begin
        errors++;
        $display("%0t: removed_value mismatch: expected %0d, actual %0d",
                 $time, exp_r.removed, removed);
      end
      if (occupancy !== exp_r.occupancy) begin
        errors++;
        $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                 $time, exp_r.occupancy, occupancy);
      end
    endfunction
  endclass

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic                     in_action    = ACT_ENQ;
  logic signed [DATA_W-1:0] in_new_value = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_removed_value;
  logic [OCC_W-1:0]         out_occupancy;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;

  min_queue_tracker queue_mirror;

  sorted_array_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", queue_mirror.pending());
    $display("testbench failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Sample both handshakes at the edge: note the input beat before the result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        queue_mirror.note_request(in_action, in_new_value);
      if (out_valid && out_ready)
        queue_mirror.check_result(out_status, out_removed_value, out_occupancy);
    end
  end

  task automatic send_item(input logic act, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_new_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom;
    if (sel < 70) return $signed($urandom_range(0, 8)) - 4;  // dense duplicates
    if (sel < 85) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh8000_0001;
        3: return 32'sh7fff_fffe;
        4: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $signed($urandom_range(0, 2000)) - 1000;
  endfunction

  // Bursts biased toward filling or draining so the store hits full and empty.
  task automatic run_random(input int n_items);
    int sent;
    int burst;
    int enq_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      repeat (burst) begin
        if ($urandom_range(0, 99) < enq_pct) send_item(ACT_ENQ, pick_value());
        else send_item(ACT_DEQ, $urandom);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    queue_mirror = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: underflow, extremes, duplicates, fill to overflow, partial drain
    send_item(ACT_DEQ, 32'sh7fff_ffff);
    send_item(ACT_ENQ, 32'sh8000_0000);
    send_item(ACT_ENQ, 32'sh7fff_ffff);
    send_item(ACT_ENQ, 32'sd0);
    send_item(ACT_ENQ, -32'sd1);
    send_item(ACT_ENQ, 32'sd1);
    send_item(ACT_ENQ, 32'sh7fff_ffff);
    send_item(ACT_ENQ, 32'sh8000_0000);
    send_item(ACT_ENQ, 32'sd5);
    send_item(ACT_ENQ, 32'sd5);
    send_item(ACT_ENQ, 32'sd5);
    send_item(ACT_ENQ, -32'sd7);
    send_item(ACT_ENQ, 32'sh5555_5555);
    send_item(ACT_ENQ, 32'shaaaa_aaaa);
    send_item(ACT_ENQ, 32'sd3);
    send_item(ACT_ENQ, -32'sd1);
    send_item(ACT_ENQ, 32'sd100);
    send_item(ACT_ENQ, 32'sd42);
    repeat (5) send_item(ACT_DEQ, 32'sh0000_0000);

    send_idle_pct = 34;
    recv_idle_pct = 46;
    run_random(560);

    send_idle_pct = 46;
    recv_idle_pct = 34;
    hold_request  = 1'b1;
    run_random(560);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(560);
    in_valid <= 1'b0;

    while (queue_mirror.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d beats: %0d enqueues (%0d overflows), %0d dequeues (%0d underflows)",
             queue_mirror.enq_count + queue_mirror.deq_count, queue_mirror.enq_count,
             queue_mirror.overflow_count, queue_mirror.deq_count,
             queue_mirror.underflow_count);
    $display("%0d results compared, peak occupancy %0d, %0d mismatches",
             queue_mirror.checked_count, queue_mirror.peak_count, queue_mirror.errors);
    if (queue_mirror.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
